/* hw/rtl/tsa_pkg.sv */
// tsa_pkg: shared widths, payload types and the cell control struct
// for the timed slot allocator; no dependencies

package tsa_pkg;

  localparam int unsigned SLOTS   = 64;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned CFG_W   = 7;

  // scan position must be able to reach SLOTS itself
  localparam int unsigned IDX_W = $clog2(SLOTS + 1);
  localparam int unsigned LIM_W = (IDX_W > CFG_W) ? IDX_W : CFG_W;

  localparam logic [CFG_W-1:0] SLOTS_IN_USE_RST = CFG_W'(64);

  typedef struct packed {
    logic [TIME_W-1:0] arrive_time;
    logic [TIME_W-1:0] leave_time;
  } req_t;

  typedef struct packed {
    logic               granted;
    logic [SLOT_W-1:0]  slot_index;
    logic               order_error;
    logic [COUNT_W-1:0] granted_count;
  } res_t;

  // broadcast from the controller to every cell of the row
  typedef struct packed {
    logic              decay;
    logic              start;
    logic              scan;
    logic [TIME_W-1:0] gap;
    logic [TIME_W-1:0] dur;
  } cell_ctl_t;

endpackage

/* hw/rtl/tsa_req_if.sv */
// tsa_req_if: request channel, valid/ready with arrival and leave time
// depends on tsa_pkg

interface tsa_req_if;
  logic          valid;
  logic          ready;
  tsa_pkg::req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/tsa_res_if.sv */
// tsa_res_if: result channel, valid/ready with one grant result
// depends on tsa_pkg

interface tsa_res_if;
  logic          valid;
  logic          ready;
  tsa_pkg::res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/tsa_cfg_if.sv */
// tsa_cfg_if: configuration write channel carrying slots_in_use
// depends on tsa_pkg

interface tsa_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [tsa_pkg::CFG_W-1:0]   slots_in_use;

  modport source (output valid, output slots_in_use, input ready);
  modport sink   (input valid, input slots_in_use, output ready);
endinterface

/* hw/rtl/tsa_cell.sv */
// tsa_cell: one slot of the row, holds its remaining busy time and the
// search token position; depends on tsa_pkg

module tsa_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tsa_pkg::cell_ctl_t ctl_i,
  input  logic               tok_i,
  output logic               tok_o,
  output logic               hit_o
);

  logic [tsa_pkg::TIME_W-1:0] rem_q, rem_d;
  logic                       tok_q, tok_d;
  logic                       hit;

  assign hit   = tok_q & ctl_i.scan & (rem_q == '0);
  assign hit_o = hit;
  // a granted cell swallows the token
  assign tok_o = tok_q & ~hit;

  always_comb begin
    tok_d = (ctl_i.start | ctl_i.scan) ? tok_i : tok_q;
    if (ctl_i.decay) begin
      rem_d = (rem_q > ctl_i.gap) ? (rem_q - ctl_i.gap) : '0;
    end else if (hit) begin
      rem_d = ctl_i.dur;
    end else begin
      rem_d = rem_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      tok_q <= 1'b0;
    end else begin
      rem_q <= rem_d;
      tok_q <= tok_d;
    end
  end

endmodule

/* hw/rtl/tsa_ctrl.sv */
// tsa_ctrl: request checking, decay and scan sequencing, grant counter,
// configuration register and output register; depends on tsa_pkg and the
// channel interfaces

module tsa_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  tsa_req_if.sink            req_i,
  tsa_res_if.source          res_o,
  tsa_cfg_if.sink            cfg_i,
  input  logic               any_hit_i,
  output tsa_pkg::cell_ctl_t ctl_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECAY,
    ST_SCAN,
    ST_EMIT
  } state_e;

  state_e                          state_q;
  logic [tsa_pkg::CFG_W-1:0]       cfg_q;
  logic [tsa_pkg::TIME_W-1:0]      last_q;
  logic [tsa_pkg::TIME_W-1:0]      gap_q;
  logic [tsa_pkg::TIME_W-1:0]      dur_q;
  logic [tsa_pkg::COUNT_W-1:0]     total_q;
  logic [tsa_pkg::IDX_W-1:0]       idx_q;
  tsa_pkg::res_t                   pend_q;
  tsa_pkg::res_t                   out_q;
  logic                            out_valid_q;

  logic                            accept;
  logic                            bad;
  logic                            out_free;
  logic                            in_range;
  logic [tsa_pkg::LIM_W-1:0]       cfg_w;
  logic [tsa_pkg::LIM_W-1:0]       limit;
  logic [tsa_pkg::COUNT_W-1:0]     total_inc;

  assign req_i.ready   = (state_q == ST_IDLE);
  assign accept        = req_i.valid & req_i.ready;
  assign cfg_i.ready   = 1'b1;
  assign res_o.valid   = out_valid_q;
  assign res_o.payload = out_q;
  assign out_free      = ~out_valid_q | res_o.ready;

  assign bad = (req_i.payload.arrive_time < last_q) ||
               (req_i.payload.leave_time <= req_i.payload.arrive_time);

  assign cfg_w    = tsa_pkg::LIM_W'(cfg_q);
  assign limit    = (cfg_w > tsa_pkg::LIM_W'(tsa_pkg::SLOTS)) ?
                    tsa_pkg::LIM_W'(tsa_pkg::SLOTS) : cfg_w;
  assign in_range = (tsa_pkg::LIM_W'(idx_q) < limit);

  // saturating grant count
  assign total_inc = (total_q == '1) ? total_q : (total_q + 1'b1);

  always_comb begin
    ctl_o.decay = (state_q == ST_DECAY);
    ctl_o.start = (state_q == ST_DECAY);
    ctl_o.scan  = (state_q == ST_SCAN) & in_range;
    ctl_o.gap   = gap_q;
    ctl_o.dur   = dur_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_q       <= tsa_pkg::SLOTS_IN_USE_RST;
      last_q      <= '0;
      gap_q       <= '0;
      dur_q       <= '0;
      total_q     <= '0;
      idx_q       <= '0;
      pend_q      <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        cfg_q <= cfg_i.slots_in_use;
      end
      // a new result may replace the one leaving in the same cycle
      if ((state_q == ST_EMIT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (bad) begin
              pend_q.granted       <= 1'b0;
              pend_q.slot_index    <= '0;
              pend_q.order_error   <= 1'b1;
              pend_q.granted_count <= total_q;
              state_q              <= ST_EMIT;
            end else begin
              last_q  <= req_i.payload.arrive_time;
              gap_q   <= req_i.payload.arrive_time - last_q;
              dur_q   <= req_i.payload.leave_time - req_i.payload.arrive_time;
              state_q <= ST_DECAY;
            end
          end
        end
        ST_DECAY: begin
          idx_q   <= '0;
          state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          if (any_hit_i) begin
            pend_q.granted       <= 1'b1;
            pend_q.slot_index    <= tsa_pkg::SLOT_W'(idx_q);
            pend_q.order_error   <= 1'b0;
            pend_q.granted_count <= total_inc;
            total_q              <= total_inc;
            state_q              <= ST_EMIT;
          end else if (!in_range) begin
            pend_q.granted       <= 1'b0;
            pend_q.slot_index    <= '0;
            pend_q.order_error   <= 1'b0;
            pend_q.granted_count <= total_q;
            state_q              <= ST_EMIT;
          end else begin
            idx_q <= idx_q + tsa_pkg::IDX_W'(1);
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_q   <= pend_q;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/timed_slot_allocator.sv */
// Timed slot allocator. Each request (arrive_time, leave_time) ages every slot
// by the time since the last accepted arrival, then hands the lowest-numbered
// free slot below slots_in_use the busy time leave - arrive. The slots form a
// row of cells; after a decay step that ages all of them at once, a search
// token walks the row one cell per cycle from slot 0 and stops at the first
// free slot. A request is taken only while idle, so the next one waits until
// this scan ends at the granted slot index, or at the effective slots_in_use
// (at most 64) when no slot is free, and the result has moved into the output
// register, where it waits while a new request is taken; a rejected request
// skips the decay and the scan. Write slots_in_use only while idle.
// Depends on tsa_pkg, the interfaces, tsa_cell and tsa_ctrl.

module timed_slot_allocator (
  input  logic      clk_i,
  input  logic      rst_ni,
  tsa_req_if.sink   req_i,
  tsa_res_if.source res_o,
  tsa_cfg_if.sink   cfg_i
);

  tsa_pkg::cell_ctl_t           ctl;
  logic [tsa_pkg::SLOTS-1:0]    tok_in;
  logic [tsa_pkg::SLOTS-1:0]    tok_out;
  logic [tsa_pkg::SLOTS-1:0]    hit;

  tsa_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .res_o     (res_o),
    .cfg_i     (cfg_i),
    .any_hit_i (|hit),
    .ctl_o     (ctl)
  );

  for (genvar k = 0; k < tsa_pkg::SLOTS; k++) begin : g_cell
    // start drops a fresh token into slot 0 and flushes any stale one
    if (k == 0) begin : g_head
      assign tok_in[k] = ctl.start;
    end else begin : g_body
      assign tok_in[k] = ~ctl.start & tok_out[k-1];
    end

    tsa_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .tok_i  (tok_in[k]),
      .tok_o  (tok_out[k]),
      .hit_o  (hit[k])
    );
  end

endmodule
